@@ rtl/hll_pkg.sv @@
// ---------------------------------------------------------------------------
// hll_pkg: shared types and constants of the distinct-count sketch
// item kinds, field widths and fixed-point constants
// ---------------------------------------------------------------------------
package hll_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ADD   = 2'd0;
  localparam kind_t KIND_MERGE = 2'd1;
  localparam kind_t KIND_EST   = 2'd2;

  localparam int RANK_W = 6;
  localparam int HASH_W = 64;
  localparam int CARD_W = 64;
  localparam int MIDX_W = 6;
  localparam int FIX_W  = 32;

  // 1 / (2 ln 2) in q0.32
  localparam logic [63:0] ALPHA_Q32 = 64'd3098164009;

  localparam int INDEX_BITS_DEF   = 6;
  localparam int SERIES_STEPS_DEF = 24;

endpackage

@@ rtl/hll_if.sv @@
// ---------------------------------------------------------------------------
// hll_if: valid/ready channels of the sketch unit
// input item channel and estimate result channel
// ---------------------------------------------------------------------------
interface hll_in_if import hll_pkg::*;;
  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [HASH_W-1:0]   hash_value;
  logic [MIDX_W-1:0]   merge_index;
  logic [RANK_W-1:0]   merge_value;

  modport source (output valid, kind, hash_value, merge_index, merge_value, input ready);
  modport sink   (input valid, kind, hash_value, merge_index, merge_value, output ready);
endinterface

interface hll_out_if import hll_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CARD_W-1:0] cardinality;
  logic              saturated;

  modport source (output valid, cardinality, saturated, input ready);
  modport sink   (input valid, cardinality, saturated, output ready);
endinterface

@@ rtl/hyperloglog_sketch_unit.sv @@
// ---------------------------------------------------------------------------
// hyperloglog_sketch_unit: distinct-count sketch with improved estimator
// rank registers and rank histogram held in registered-read synchronous memories
// ---------------------------------------------------------------------------
// in_if beats carry a kind: add (a 64-bit hash), merge (one register of
// another sketch) or estimate; kind 3 is taken and dropped. out_if gives
// one beat per estimate: cardinality in unsigned q56.8 and a saturated flag.
// add and merge are a read-modify-write of the rank memory through the
// single port pair: read in ST_IDLE, in ST_RMW written back if larger.
// an estimate runs a sequencer: histogram clear, register sweep (read,
// histogram read, histogram write per register), sigma series (square,
// accumulate), tau series (bit-serial square root, square, subtract),
// divide by three, histogram fold (read, accumulate per rank) and a
// 64-bit restoring divider. an empty sketch skips the series.
// after reset the rank memory is cleared, one entry a cycle, all
// 2^INDEX_BITS entries, with in_if.ready low.
// a finished estimate waits in the output register; while out_if is
// stalled add and merge beats are still taken, and a following estimate
// holds at its end until the output register is free.
// ---------------------------------------------------------------------------
module hyperloglog_sketch_unit import hll_pkg::*; #(
  parameter int INDEX_BITS   = INDEX_BITS_DEF,
  parameter int SERIES_STEPS = SERIES_STEPS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  hll_in_if.sink     in_if,
  hll_out_if.source  out_if
);

  localparam int REG_COUNT  = 1 << INDEX_BITS;
  localparam int Q_BITS     = 64 - INDEX_BITS;
  localparam int MAX_RANK   = Q_BITS + 1;
  localparam int HIST_DEPTH = Q_BITS + 2;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int HC_W       = INDEX_BITS + 1;
  localparam int CNT_W      = (INDEX_BITS > 7) ? INDEX_BITS : 7;
  localparam logic [63:0] NUM = ALPHA_Q32 << (2 * INDEX_BITS + 8);

  // sequencer states
  localparam logic [4:0] ST_INIT  = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_RMW   = 5'd2;
  localparam logic [4:0] ST_HCLR  = 5'd3;
  localparam logic [4:0] ST_SWRD  = 5'd4;
  localparam logic [4:0] ST_SWHRD = 5'd5;
  localparam logic [4:0] ST_SWHWR = 5'd6;
  localparam logic [4:0] ST_CHECK = 5'd7;
  localparam logic [4:0] ST_SMUL  = 5'd8;
  localparam logic [4:0] ST_SACC  = 5'd9;
  localparam logic [4:0] ST_TINIT = 5'd10;
  localparam logic [4:0] ST_SQRT  = 5'd11;
  localparam logic [4:0] ST_TMUL  = 5'd12;
  localparam logic [4:0] ST_TSUB  = 5'd13;
  localparam logic [4:0] ST_DIV3  = 5'd14;
  localparam logic [4:0] ST_ZRD   = 5'd15;
  localparam logic [4:0] ST_ZACC  = 5'd16;
  localparam logic [4:0] ST_ZFIN  = 5'd17;
  localparam logic [4:0] ST_DCHK  = 5'd18;
  localparam logic [4:0] ST_DIV   = 5'd19;
  localparam logic [4:0] ST_DONE  = 5'd20;

  logic [4:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [5:0]            step_r, step_nxt;
  logic [4:0]            sq_cnt_r, sq_cnt_nxt;

  // rank memory
  logic [RANK_W-1:0]     rmem [REG_COUNT];
  logic                  rm_we;
  logic [INDEX_BITS-1:0] rm_waddr, rm_raddr;
  logic [RANK_W-1:0]     rm_wdata, rm_rdata_r;

  // histogram memory
  logic [HC_W-1:0]       hmem [HIST_DEPTH];
  logic                  hm_we;
  logic [HA_W-1:0]       hm_waddr, hm_raddr;
  logic [HC_W-1:0]       hm_wdata, hm_rdata_r;

  // add / merge operands
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [RANK_W-1:0]     nv_r, nv_nxt;
  logic [INDEX_BITS-1:0] in_idx;
  logic [RANK_W-1:0]     in_rank;

  // estimate datapath
  logic [RANK_W-1:0]     vr_r, vr_nxt;
  logic [HC_W-1:0]       c0_r, c0_nxt, cmax_r, cmax_nxt;
  logic [FIX_W-1:0]      sx_r, sx_nxt;
  logic [63:0]           ss_r, ss_nxt;
  logic [FIX_W-1:0]      tx_r, tx_nxt, tz_r, tz_nxt;
  logic [63:0]           sn_r, sn_nxt;
  logic [33:0]           rem_r, rem_nxt;
  logic [FIX_W-1:0]      root_r, root_nxt;
  logic [33:0]           tt_r, tt_nxt;
  logic [63:0]           zacc_r, zacc_nxt;
  logic [63:0]           dq_r, dq_nxt, drem_r, drem_nxt;
  logic                  rsat_r, rsat_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [CARD_W-1:0]     out_card_r, out_card_nxt;
  logic                  out_sat_r, out_sat_nxt;

  logic                  in_take;
  logic                  out_free;
  logic [RANK_W-1:0]     sweep_v;

  assign in_if.ready        = (state_r == ST_IDLE);
  assign in_take            = in_if.valid && in_if.ready;
  assign out_if.valid       = out_valid_r;
  assign out_if.cardinality = out_card_r;
  assign out_if.saturated   = out_sat_r;
  assign out_free           = !out_valid_r || out_if.ready;

  // rank of an added hash: one plus the leading zeros below the index bits, stop bit caps it
  always_comb begin
    logic [63:0] w;
    logic [5:0]  hb;
    w  = (in_if.hash_value << INDEX_BITS) | (64'd1 << (INDEX_BITS - 1));
    hb = '0;
    for (int b = 0; b < 64; b++) begin
      if (w[b]) hb = 6'(b);
    end
    in_rank = RANK_W'(7'd64 - {1'b0, hb});
  end

  always_comb begin
    if (in_if.kind == KIND_ADD) begin
      in_idx = in_if.hash_value[63 -: INDEX_BITS];
    end else begin
      in_idx = INDEX_BITS'(in_if.merge_index);
    end
  end

  // stored ranks never pass the cap, clamp kept for safety
  assign sweep_v = (rm_rdata_r > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : rm_rdata_r;

  // memories
  always_ff @(posedge clk) begin
    if (rm_we) begin
      rmem[rm_waddr] <= rm_wdata;
    end
    rm_rdata_r <= rmem[rm_raddr];
  end

  always_ff @(posedge clk) begin
    if (hm_we) begin
      hmem[hm_waddr] <= hm_wdata;
    end
    hm_rdata_r <= hmem[hm_raddr];
  end

  // memory port control
  always_comb begin
    rm_we    = 1'b0;
    rm_waddr = cnt_r[INDEX_BITS-1:0];
    rm_wdata = '0;
    rm_raddr = cnt_r[INDEX_BITS-1:0];
    hm_we    = 1'b0;
    hm_waddr = cnt_r[HA_W-1:0];
    hm_wdata = '0;
    hm_raddr = cnt_r[HA_W-1:0];
    case (state_r)
      ST_INIT: begin
        rm_we = 1'b1;
      end
      ST_IDLE: begin
        rm_raddr = in_idx;
      end
      ST_RMW: begin
        rm_we    = (nv_r > rm_rdata_r);
        rm_waddr = idx_r;
        rm_wdata = nv_r;
      end
      ST_HCLR: begin
        hm_we = 1'b1;
      end
      ST_SWHRD: begin
        hm_raddr = HA_W'(sweep_v);
      end
      ST_SWHWR: begin
        hm_we    = 1'b1;
        hm_waddr = HA_W'(vr_r);
        hm_wdata = hm_rdata_r + HC_W'(1);
      end
      default: begin
      end
    endcase
  end

  // sequencer and datapath
  always_comb begin
    logic [63:0]  prod;
    logic [95:0]  wide;
    logic [63:0]  sh;
    logic [64:0]  sum;
    logic [33:0]  rn, trial;
    logic [32:0]  d;
    logic [65:0]  dd;
    logic [64:0]  r2;
    logic [CNT_W-1:0] free_cnt;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    sq_cnt_nxt    = sq_cnt_r;
    idx_nxt       = idx_r;
    nv_nxt        = nv_r;
    vr_nxt        = vr_r;
    c0_nxt        = c0_r;
    cmax_nxt      = cmax_r;
    sx_nxt        = sx_r;
    ss_nxt        = ss_r;
    tx_nxt        = tx_r;
    tz_nxt        = tz_r;
    sn_nxt        = sn_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    tt_nxt        = tt_r;
    zacc_nxt      = zacc_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    rsat_nxt      = rsat_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_card_nxt  = out_card_r;
    out_sat_nxt   = out_sat_r;
    prod  = '0;
    wide  = '0;
    sh    = '0;
    sum   = '0;
    rn    = '0;
    trial = '0;
    d     = '0;
    dd    = '0;
    r2    = '0;
    free_cnt = CNT_W'(REG_COUNT - 1);

    case (state_r)
      ST_INIT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == free_cnt) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          idx_nxt = in_idx;
          case (in_if.kind)
            KIND_ADD: begin
              nv_nxt    = in_rank;
              state_nxt = ST_RMW;
            end
            KIND_MERGE: begin
              nv_nxt = (in_if.merge_value > RANK_W'(MAX_RANK)) ?
                       RANK_W'(MAX_RANK) : in_if.merge_value;
              state_nxt = ST_RMW;
            end
            KIND_EST: begin
              cnt_nxt   = '0;
              state_nxt = ST_HCLR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RMW: begin
        state_nxt = ST_IDLE;
      end
      ST_HCLR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(HIST_DEPTH - 1)) begin
          cnt_nxt   = '0;
          c0_nxt    = '0;
          cmax_nxt  = '0;
          state_nxt = ST_SWRD;
        end
      end
      ST_SWRD: begin
        state_nxt = ST_SWHRD;
      end
      ST_SWHRD: begin
        vr_nxt = sweep_v;
        if (sweep_v == '0) c0_nxt = c0_r + HC_W'(1);
        if (sweep_v == RANK_W'(MAX_RANK)) cmax_nxt = cmax_r + HC_W'(1);
        state_nxt = ST_SWHWR;
      end
      ST_SWHWR: begin
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = ST_SWRD;
        if (cnt_r == free_cnt) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (c0_r == HC_W'(REG_COUNT)) begin
          // empty sketch
          dq_nxt    = '0;
          rsat_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          sx_nxt    = {c0_r[INDEX_BITS-1:0], {(FIX_W - INDEX_BITS){1'b0}}};
          ss_nxt    = 64'({c0_r[INDEX_BITS-1:0], {(FIX_W - INDEX_BITS){1'b0}}});
          step_nxt  = '0;
          state_nxt = ST_SMUL;
        end
      end
      ST_SMUL: begin
        prod      = 64'(sx_r) * 64'(sx_r);
        sx_nxt    = prod[63:32];
        state_nxt = ST_SACC;
      end
      ST_SACC: begin
        wide     = 96'(sx_r) << step_r;
        sh       = (|wide[95:64]) ? '1 : wide[63:0];
        sum      = {1'b0, ss_r} + {1'b0, sh};
        ss_nxt   = sum[64] ? '1 : sum[63:0];
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(SERIES_STEPS - 1)) state_nxt = ST_TINIT;
        else state_nxt = ST_SMUL;
      end
      ST_TINIT: begin
        step_nxt = '0;
        if (cmax_r == '0 || cmax_r == HC_W'(REG_COUNT)) begin
          // tau vanishes at both ends
          zacc_nxt  = '0;
          cnt_nxt   = CNT_W'(Q_BITS);
          state_nxt = ST_ZRD;
        end else begin
          tx_nxt = {INDEX_BITS'(HC_W'(REG_COUNT) - cmax_r),
                    {(FIX_W - INDEX_BITS){1'b0}}};
          tz_nxt = FIX_W'(33'h1_0000_0000 - 33'({INDEX_BITS'(HC_W'(REG_COUNT) - cmax_r),
                    {(FIX_W - INDEX_BITS){1'b0}}}));
          sn_nxt     = {{INDEX_BITS'(HC_W'(REG_COUNT) - cmax_r),
                         {(FIX_W - INDEX_BITS){1'b0}}}, 32'd0};
          rem_nxt    = '0;
          root_nxt   = '0;
          sq_cnt_nxt = '0;
          state_nxt  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one root bit a cycle
        rn    = {rem_r[31:0], sn_r[63:62]};
        trial = {root_r, 2'b01};
        if (rn >= trial) begin
          rem_nxt  = rn - trial;
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt  = rn;
          root_nxt = {root_r[30:0], 1'b0};
        end
        sn_nxt     = {sn_r[61:0], 2'b00};
        sq_cnt_nxt = sq_cnt_r + 5'd1;
        if (sq_cnt_r == 5'd31) begin
          tx_nxt    = root_nxt;
          state_nxt = ST_TMUL;
        end
      end
      ST_TMUL: begin
        d         = 33'h1_0000_0000 - 33'(tx_r);
        dd        = 66'(d) * 66'(d);
        tt_nxt    = dd[65:32] >> ({1'b0, step_r} + 7'd1);
        state_nxt = ST_TSUB;
      end
      ST_TSUB: begin
        tz_nxt   = (34'(tz_r) > tt_r) ? tz_r - tt_r[31:0] : '0;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(SERIES_STEPS - 1)) begin
          state_nxt = ST_DIV3;
        end else begin
          sn_nxt     = {tx_r, 32'd0};
          rem_nxt    = '0;
          root_nxt   = '0;
          sq_cnt_nxt = '0;
          state_nxt  = ST_SQRT;
        end
      end
      ST_DIV3: begin
        // divide by three as a reciprocal multiply
        prod      = 64'(tz_r) * 64'hAAAA_AAAB;
        zacc_nxt  = 64'(prod[63:33]) << INDEX_BITS;
        cnt_nxt   = CNT_W'(Q_BITS);
        state_nxt = ST_ZRD;
      end
      ST_ZRD: begin
        state_nxt = ST_ZACC;
      end
      ST_ZACC: begin
        zacc_nxt = (zacc_r + (64'(hm_rdata_r) << 32)) >> 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) state_nxt = ST_ZFIN;
        else state_nxt = ST_ZRD;
      end
      ST_ZFIN: begin
        sh        = (|ss_r[63 -: INDEX_BITS]) ? '1 : (ss_r << INDEX_BITS);
        sum       = {1'b0, zacc_r} + {1'b0, sh};
        zacc_nxt  = sum[64] ? '1 : sum[63:0];
        state_nxt = ST_DCHK;
      end
      ST_DCHK: begin
        if (zacc_r == '0) begin
          dq_nxt    = '1;
          rsat_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          dq_nxt    = NUM;
          drem_nxt  = '0;
          rsat_nxt  = 1'b0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divider, one quotient bit a cycle
        r2 = {drem_r, dq_r[63]};
        if (r2 >= {1'b0, zacc_r}) begin
          drem_nxt = 64'(r2 - {1'b0, zacc_r});
          dq_nxt   = {dq_r[62:0], 1'b1};
        end else begin
          drem_nxt = r2[63:0];
          dq_nxt   = {dq_r[62:0], 1'b0};
        end
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd63) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_card_nxt  = dq_r;
          out_sat_nxt   = rsat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      step_r      <= '0;
      sq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    nv_r       <= nv_nxt;
    vr_r       <= vr_nxt;
    c0_r       <= c0_nxt;
    cmax_r     <= cmax_nxt;
    sx_r       <= sx_nxt;
    ss_r       <= ss_nxt;
    tx_r       <= tx_nxt;
    tz_r       <= tz_nxt;
    sn_r       <= sn_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    tt_r       <= tt_nxt;
    zacc_r     <= zacc_nxt;
    dq_r       <= dq_nxt;
    drem_r     <= drem_nxt;
    rsat_r     <= rsat_nxt;
    out_card_r <= out_card_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  // checks
  a_est_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_if.kind == KIND_EST |=> !in_if.ready)
    else $error("estimate beat did not block the input");

  a_rank_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rm_we |-> rm_wdata <= RANK_W'(MAX_RANK))
    else $error("rank written above the cap");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished estimate not loaded");

  a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> (c0_r <= HC_W'(REG_COUNT) && cmax_r <= HC_W'(REG_COUNT)))
    else $error("histogram end counts exceed register count");

endmodule
